/* hdl/sfr_pkg.sv */
// Shared types and constants for the stuffed frame receiver.
// Holds the register indexes, the configuration and result structs and the phase codes.
// No dependencies.
`default_nettype none

package sfr_pkg;

	// Configuration register indexes.
	localparam logic [2:0] REG_START_SYMBOL    = 3'd0;
	localparam logic [2:0] REG_TYPE_MASK       = 3'd1;
	localparam logic [2:0] REG_LOCAL_DEST_MASK = 3'd2;
	localparam logic [2:0] REG_TYPE_COUNT      = 3'd3;
	localparam logic [2:0] REG_PAYLOAD_SIZES_0 = 3'd4;
	localparam logic [2:0] REG_PAYLOAD_SIZES_1 = 3'd5;
	localparam logic [2:0] REG_PAYLOAD_SIZES_2 = 3'd6;
	localparam logic [2:0] REG_PAYLOAD_SIZES_3 = 3'd7;

	localparam int CFG_DATA_W = 64;
	localparam int MAX_TYPES  = 32;

	// Verdict codes.
	localparam logic [1:0] VERDICT_OK       = 2'd0;
	localparam logic [1:0] VERDICT_CHECKSUM = 2'd1;
	localparam logic [1:0] VERDICT_TYPE     = 2'd2;
	localparam logic [1:0] VERDICT_OVERFLOW = 2'd3;

	// Result kinds carried on tuser.
	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_VERDICT = 1'b1;

	typedef enum logic [1:0] {
		PH_WAIT,
		PH_START,
		PH_DATA
	} phase_t;

	// Live configuration seen by the decoder.
	typedef struct packed {
		logic [7:0]            start_symbol;
		logic [7:0]            type_mask;
		logic [7:0]            local_dest_mask;
		logic [5:0]            type_count;
		logic [3:0][7:0][7:0]  payload_sizes;
	} cfg_t;

	// Result fields in tdata order, lowest bit last in this list.
	typedef struct packed {
		logic       deliver_local;
		logic [1:0] verdict;
		logic [7:0] param_bits;
		logic [4:0] frame_kind;
		logic [7:0] payload_byte;
	} res_t;

endpackage

`default_nettype wire

/* hdl/stuffed_frame_receiver.sv */
// Top level of the stuffed frame receiver.
// Instantiates sfr_cfg and sfr_core; depends on sfr_pkg.
`default_nettype none

// Byte-stuffed frame receiver. Raw link bytes enter on the slave stream, one per
// transfer. A start symbol opens a frame and a doubled start symbol is a literal
// byte. Payload bytes leave as they arrive (tuser 0). Each frame not cut short
// by a new start symbol ends with one verdict transfer (tuser 1): ok, checksum
// error, unsupported type or overflow. The block takes one byte per clock while
// the output is not stalled; each byte passes the input register and then the
// result register. Configuration is written through cfg_we, cfg_index and
// cfg_data; the user must do so only while idle. The block does not enforce it.
module stuffed_frame_receiver #(
	parameter int MAX_FRAME_BYTES = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [63:0] cfg_data,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] byte_in
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata,   // [7:0] payload_byte, [12:8] frame_kind,
	                                    // [20:13] param_bits, [22:21] verdict,
	                                    // [23] deliver_local
	output logic             m_tuser    // [0] kind
);
	import sfr_pkg::*;

	cfg_t cfg;
	res_t res;

	sfr_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	sfr_core #(
		.MAX_FRAME_BYTES (MAX_FRAME_BYTES)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_res    (res),
		.m_kind   (m_tuser)
	);

	assign m_tdata = res;

endmodule

`default_nettype wire

/* hdl/sfr_cfg.sv */
// Configuration register file of the stuffed frame receiver.
// Takes writes from the plain write port; depends on sfr_pkg.
`default_nettype none

module sfr_cfg (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_we,
	input  wire logic [2:0]                           cfg_index,
	input  wire logic [sfr_pkg::CFG_DATA_W-1:0]       cfg_data,
	output sfr_pkg::cfg_t                             cfg
);
	import sfr_pkg::*;

	cfg_t cfg_q;

	// Register writes; every index of the port maps to a register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_symbol    <= 8'd0;
			cfg_q.type_mask       <= 8'd31;
			cfg_q.local_dest_mask <= 8'd128;
			cfg_q.type_count      <= 6'd21;
			cfg_q.payload_sizes   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_START_SYMBOL:    cfg_q.start_symbol    <= cfg_data[7:0];
				REG_TYPE_MASK:       cfg_q.type_mask       <= cfg_data[7:0];
				REG_LOCAL_DEST_MASK: cfg_q.local_dest_mask <= cfg_data[7:0];
				REG_TYPE_COUNT:      cfg_q.type_count      <= cfg_data[5:0];
				REG_PAYLOAD_SIZES_0: cfg_q.payload_sizes[0] <= cfg_data;
				REG_PAYLOAD_SIZES_1: cfg_q.payload_sizes[1] <= cfg_data;
				REG_PAYLOAD_SIZES_2: cfg_q.payload_sizes[2] <= cfg_data;
				REG_PAYLOAD_SIZES_3: cfg_q.payload_sizes[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

/* hdl/sfr_core.sv */
// Decoder datapath: input register, frame state, decode logic and result register.
// Depends on sfr_pkg; configuration comes from sfr_cfg.
`default_nettype none

module sfr_core #(
	parameter int MAX_FRAME_BYTES = 64
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire sfr_pkg::cfg_t cfg,
	input  wire logic          s_tvalid,
	output logic               s_tready,
	input  wire logic [7:0]    s_tdata,
	output logic               m_tvalid,
	input  wire logic          m_tready,
	output sfr_pkg::res_t      m_res,
	output logic               m_kind
);
	import sfr_pkg::*;

	localparam int PW = $clog2(MAX_FRAME_BYTES + 2);

	// Input stage.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       advance;

	// Frame state.
	phase_t     phase_q, phase_n;
	logic [PW-1:0] pos_q, pos_n;
	logic [7:0] sum_q, sum_n;
	logic [8:0] exp_q, exp_n;
	logic [4:0] type_q, type_n;
	logic [7:0] params_q, params_n;

	// Result stage.
	logic       m_valid_q;
	res_t       res_q, res_n;
	logic       kind_q, kind_n;
	logic       emit;

	// Decode temporaries.
	logic          take;
	logic          esc;
	logic          ended;
	logic [PW-1:0] pos_t;
	logic [7:0]    t;
	logic [5:0]    limit;

	assign advance  = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	assign limit = (cfg.type_count > 6'(MAX_TYPES)) ? 6'(MAX_TYPES) : cfg.type_count;

	// Unstuffing, framing and checksum for the byte in the input register.
	always_comb begin
		phase_n  = phase_q;
		pos_n    = pos_q;
		sum_n    = sum_q;
		exp_n    = exp_q;
		type_n   = type_q;
		params_n = params_q;
		take     = 1'b0;
		ended    = 1'b0;
		emit     = 1'b0;
		kind_n   = KIND_PAYLOAD;
		pos_t    = pos_q;
		t        = byte_s1 & cfg.type_mask;
		esc      = (phase_q == PH_START) && (byte_s1 == cfg.start_symbol);

		unique case (phase_q)
			PH_WAIT: begin
				if (byte_s1 == cfg.start_symbol) begin
					phase_n = PH_START;
				end
			end
			PH_START: begin
				take    = 1'b1;
				phase_n = PH_DATA;
				if (esc) begin
					pos_t = pos_q + 1'b1;
					sum_n = sum_q + byte_s1;
				end else begin
					pos_t = PW'(1);
					sum_n = byte_s1;
				end
			end
			PH_DATA: begin
				if (byte_s1 == cfg.start_symbol) begin
					phase_n = PH_START;
				end else begin
					take  = 1'b1;
					pos_t = pos_q + 1'b1;
					sum_n = sum_q + byte_s1;
				end
			end
			default: phase_n = PH_WAIT;
		endcase

		if (take) begin
			pos_n = pos_t;
			priority if (pos_t == PW'(1)) begin
				// Type byte: split into type and parameter bits.
				type_n   = t[4:0];
				params_n = byte_s1 & ~cfg.type_mask;
				if (t >= {2'b00, limit}) begin
					emit   = 1'b1;
					kind_n = KIND_VERDICT;
					ended  = 1'b1;
				end else begin
					exp_n = {1'b0, cfg.payload_sizes[t[4:3]][t[2:0]]} + 9'd2;
				end
			end else if (pos_t > PW'(MAX_FRAME_BYTES)) begin
				emit   = 1'b1;
				kind_n = KIND_VERDICT;
				ended  = 1'b1;
			end else if ({{(9 - PW){1'b0}}, pos_t} == exp_q) begin
				// Checksum byte; an escaped one is not part of the sum.
				if (esc) begin
					sum_n = sum_q;
				end
				emit   = 1'b1;
				kind_n = KIND_VERDICT;
				ended  = 1'b1;
			end else begin
				emit = 1'b1;
			end
			if (ended) begin
				phase_n = PH_WAIT;
				pos_n   = '0;
			end
		end
	end

	// Result fields for the byte being decoded.
	always_comb begin
		res_n.payload_byte  = 8'd0;
		res_n.frame_kind    = type_n;
		res_n.param_bits    = params_n;
		res_n.verdict       = VERDICT_OK;
		res_n.deliver_local = 1'b0;
		if (kind_n == KIND_PAYLOAD) begin
			res_n.payload_byte = byte_s1;
		end else if (pos_t == PW'(1)) begin
			res_n.verdict = VERDICT_TYPE;
		end else if (pos_t > PW'(MAX_FRAME_BYTES)) begin
			res_n.verdict = VERDICT_OVERFLOW;
		end else if (byte_s1 != sum_q) begin
			res_n.verdict = VERDICT_CHECKSUM;
		end else begin
			res_n.deliver_local = (params_q & cfg.local_dest_mask) != 8'd0;
		end
	end

	// Frame state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_WAIT;
			pos_q    <= '0;
			sum_q    <= 8'd0;
			exp_q    <= 9'd0;
			type_q   <= 5'd0;
			params_q <= 8'd0;
		end else if (advance) begin
			phase_q  <= phase_n;
			pos_q    <= pos_n;
			sum_q    <= sum_n;
			exp_q    <= exp_n;
			type_q   <= type_n;
			params_q <= params_n;
		end
	end

	// Result register; it holds while the downstream side stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= emit;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			res_q  <= res_n;
			kind_q <= kind_n;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_res    = res_q;
	assign m_kind   = kind_q;

endmodule

`default_nettype wire
